// ===== src/rgb_led_effect_sequencer_assert.svh =====
// Assertion macros for the LED effect sequencer checks.
// Used by rles_checker.sv; no other dependencies.
`ifndef RGB_LED_EFFECT_SEQUENCER_ASSERT_SVH
`define RGB_LED_EFFECT_SEQUENCER_ASSERT_SVH

// Same-cycle implication.
`define RLES_ASSERT_IMP(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("rles check failed");

// Next-cycle implication.
`define RLES_ASSERT_NXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("rles check failed");

`endif

// ===== src/rles_pkg.sv =====
// Shared types and constants for the LED effect sequencer.
// No dependencies; imported by every module of the block.
package rles_pkg;

    // commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_NEXT  = 2'd1;
    localparam logic [1:0] CMD_POWER = 2'd2;

    // programs
    localparam logic [2:0] PROG_BLIP    = 3'd0;
    localparam logic [2:0] PROG_WHITE   = 3'd1;
    localparam logic [2:0] PROG_RAINBOW = 3'd2;
    localparam logic [2:0] PROG_PULSE   = 3'd3;
    localparam logic [2:0] PROG_FLASH   = 3'd4;

    // effect phases (rainbow: red->blue, blue->green, green->red)
    localparam logic [1:0] PH_WAIT     = 2'd0;
    localparam logic [1:0] PH_FADE_IN  = 2'd1;
    localparam logic [1:0] PH_HOLD     = 2'd2;
    localparam logic [1:0] PH_FADE_OUT = 2'd3;

    // pulse channel order; the fourth code steps nothing
    localparam logic [1:0] PCH_RED   = 2'd0;
    localparam logic [1:0] PCH_BLUE  = 2'd1;
    localparam logic [1:0] PCH_GREEN = 2'd2;
    localparam logic [1:0] PCH_NONE  = 2'd3;

    // fade unit channel order
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam int DIV_ITERS = 8;   // 16 dividend bits, 2 per cycle

    typedef enum logic [1:0] {
        FM_TO_WHITE,    // target -> 255
        FM_FROM_WHITE,  // 255 -> target
        FM_UP,          // 0 -> target
        FM_DOWN         // target -> 0
    } t_fade_mode;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ISSUE,
        CS_WAIT,
        CS_DONE
    } t_core_state;

    typedef enum logic [1:0] {
        FD_IDLE,
        FD_DIV,
        FD_FIN
    } t_fade_state;

    typedef struct packed {
        logic [7:0] count;
        logic [7:0] span;
        logic [7:0] from;
        logic [7:0] to;
    } t_fade_req;

    typedef struct packed {
        logic [2:0] program_now;
        logic       leds_on;
        logic [7:0] blue_pwm;
        logic [7:0] green_pwm;
        logic [7:0] red_pwm;
    } t_result;

endpackage

// ===== src/rles_fade_unit.sv =====
// Shared fade interpolator: count*(to-from)/span + from, truncating toward zero.
// Multiply at start, 8 radix-4 restoring divide iterations, one finish step.
// Depends on rles_pkg.
module rles_fade_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  rles_pkg::t_fade_req i_req,
    output logic                o_done,
    output logic [7:0]          o_level
);
    import rles_pkg::*;

    localparam int ITER_W = $clog2(DIV_ITERS);

    t_fade_state       r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic              r_done, n_done;
    logic [15:0]       r_quo, n_quo;   // dividend shifts out on top, quotient in below
    logic [7:0]        r_rem, n_rem;
    logic [7:0]        r_span, r_from, r_level, n_level;
    logic              r_neg, r_zero;

    logic signed [8:0]  w_diff;
    logic signed [17:0] w_prod;
    logic [17:0]        w_mag;

    assign w_diff = $signed({1'b0, i_req.to}) - $signed({1'b0, i_req.from});
    assign w_prod = $signed({10'd0, i_req.count}) * $signed({{9{w_diff[8]}}, w_diff});
    assign w_mag  = w_prod[17] ? 18'(-w_prod) : w_prod;

    always_comb begin
        logic [8:0]  sh;
        logic [7:0]  rem;
        logic [15:0] quo;
        logic [7:0]  q8;
        n_state = r_state;
        n_iter  = r_iter;
        n_done  = 1'b0;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_level = r_level;
        sh      = 9'd0;
        rem     = r_rem;
        quo     = r_quo;
        q8      = r_neg ? 8'(~r_quo[7:0] + 8'd1) : r_quo[7:0];
        case (r_state)
            FD_IDLE: begin
                if (i_start) begin
                    n_quo   = w_mag[15:0];
                    n_rem   = 8'd0;
                    n_iter  = '0;
                    n_state = FD_DIV;
                end
            end
            FD_DIV: begin
                for (int k = 0; k < 2; k++) begin
                    sh  = {rem, quo[15]};
                    quo = {quo[14:0], 1'b0};
                    if (sh >= {1'b0, r_span}) begin
                        rem    = 8'(sh - {1'b0, r_span});
                        quo[0] = 1'b1;
                    end else begin
                        rem = sh[7:0];
                    end
                end
                n_quo  = quo;
                n_rem  = rem;
                n_iter = r_iter + ITER_W'(1);
                if (r_iter == ITER_W'(DIV_ITERS - 1)) begin
                    n_state = FD_FIN;
                end
            end
            FD_FIN: begin
                n_level = r_zero ? r_from : 8'(q8 + r_from);
                n_done  = 1'b1;
                n_state = FD_IDLE;
            end
            default: n_state = FD_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FD_IDLE;
            r_iter  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_level <= n_level;
        if (r_state == FD_IDLE && i_start) begin
            r_span <= i_req.span;
            r_from <= i_req.from;
            r_neg  <= w_prod[17];
            r_zero <= (i_req.span == 8'd0);
        end
    end

    assign o_done  = r_done;
    assign o_level = r_level;

endmodule

// ===== src/rles_core.sv =====
// Effect state and sequencer: applies one command, then runs the fade
// unit once per color channel when the step needs a fade.
// Depends on rles_pkg.
module rles_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_cmd,
    input  logic [14:0]         i_rand0,
    input  logic [7:0]          i_rand1,
    input  logic [7:0]          i_rand2,
    input  logic [7:0]          i_rand3,
    output logic                o_ready,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output rles_pkg::t_result   o_res,
    output logic                o_fade_start,
    output rles_pkg::t_fade_req o_fade_req,
    input  logic                i_fade_done,
    input  logic [7:0]          i_fade_level
);
    import rles_pkg::*;

    // (d mod 254) + 1: fold the upper half mod 127, low bit passes through
    function automatic logic [7:0] span_from_draw(input logic [14:0] d);
        logic [7:0] s;
        s = {1'b0, d[7:1]} + {1'b0, d[14:8]};
        if (s >= 8'd127) s = s - 8'd127;
        if (s >= 8'd127) s = s - 8'd127;
        return 8'({s[6:0], d[0]} + 8'd1);
    endfunction

    t_core_state r_state, n_state;
    logic [1:0]  r_chan, n_chan;
    t_fade_mode  r_fmode, n_fmode;
    logic [7:0]  r_fcount, n_fcount;

    logic [2:0]  r_prog, n_prog;
    logic        r_power, n_power;
    logic [7:0]  r_red, n_red, r_green, n_green, r_blue, n_blue;
    logic [1:0]  r_phase, n_phase;
    logic [7:0]  r_step, n_step, r_span, n_span;
    logic [7:0]  r_tr, n_tr, r_tg, n_tg, r_tb, n_tb;
    logic        r_rising, n_rising;
    logic [1:0]  r_pch, n_pch;

    logic [7:0] w_s64, w_s1, w_s127;
    assign w_s64  = {2'b00, i_rand0[5:0]} + 8'd64;
    assign w_s1   = {2'b00, i_rand0[5:0]} + 8'd1;
    assign w_s127 = {1'b0, i_rand0[6:0]} + 8'd127;

    always_comb begin
        logic [7:0] sc;
        logic [7:0] p_lvl, p_new;
        logic       need_fade;
        n_state  = r_state;
        n_chan   = r_chan;
        n_fmode  = r_fmode;
        n_fcount = r_fcount;
        n_prog   = r_prog;
        n_power  = r_power;
        n_red    = r_red;
        n_green  = r_green;
        n_blue   = r_blue;
        n_phase  = r_phase;
        n_step   = r_step;
        n_span   = r_span;
        n_tr     = r_tr;
        n_tg     = r_tg;
        n_tb     = r_tb;
        n_rising = r_rising;
        n_pch    = r_pch;
        need_fade = 1'b0;
        sc       = 8'd0;
        p_lvl    = 8'd0;
        p_new    = 8'd0;

        case (r_state)
            CS_IDLE: begin
                if (i_start) begin
                    case (i_cmd)
                        CMD_TICK: begin
                            case (r_prog)
                                PROG_BLIP: begin
                                    sc       = r_step - 8'd1;
                                    n_step   = sc;
                                    n_fcount = sc;
                                    case (r_phase)
                                        PH_WAIT: begin
                                            if (sc == 8'd0) begin
                                                n_phase = PH_FADE_IN;
                                                n_step  = w_s64;
                                                n_span  = w_s64;
                                                n_tb    = i_rand1;
                                                n_tr    = i_rand2;
                                                n_tg    = i_rand3;
                                            end
                                        end
                                        PH_FADE_IN: begin
                                            need_fade = 1'b1;
                                            n_fmode   = FM_TO_WHITE;
                                            if (sc == 8'd0) begin
                                                n_phase = PH_HOLD;
                                                n_step  = w_s1;
                                            end
                                        end
                                        PH_HOLD: begin
                                            if (sc == 8'd0) begin
                                                n_phase = PH_FADE_OUT;
                                                n_step  = w_s64;
                                                n_span  = w_s64;
                                            end
                                        end
                                        default: begin
                                            need_fade = 1'b1;
                                            n_fmode   = FM_FROM_WHITE;
                                            if (sc == 8'd0) begin
                                                n_phase = PH_WAIT;
                                                n_step  = w_s127;
                                            end
                                        end
                                    endcase
                                end
                                PROG_RAINBOW: begin
                                    case (r_phase)
                                        PH_WAIT: begin
                                            n_red  = r_red - 8'd1;
                                            n_blue = r_blue + 8'd1;
                                            if (n_red == 8'd0) n_phase = PH_FADE_IN;
                                        end
                                        PH_FADE_IN: begin
                                            n_blue  = r_blue - 8'd1;
                                            n_green = r_green + 8'd1;
                                            if (n_blue == 8'd0) n_phase = PH_HOLD;
                                        end
                                        PH_HOLD: begin
                                            n_green = r_green - 8'd1;
                                            n_red   = r_red + 8'd1;
                                            if (n_green == 8'd0) n_phase = PH_WAIT;
                                        end
                                        default: n_phase = PH_WAIT;
                                    endcase
                                end
                                PROG_PULSE: begin
                                    case (r_pch)
                                        PCH_RED:   p_lvl = r_red;
                                        PCH_BLUE:  p_lvl = r_blue;
                                        default:   p_lvl = r_green;
                                    endcase
                                    p_new = r_rising ? p_lvl + 8'd1 : p_lvl - 8'd1;
                                    if (r_pch != PCH_NONE) begin
                                        case (r_pch)
                                            PCH_RED:  n_red   = p_new;
                                            PCH_BLUE: n_blue  = p_new;
                                            default:  n_green = p_new;
                                        endcase
                                        if (r_rising) begin
                                            if (p_new == 8'd255) n_rising = 1'b0;
                                        end else if (p_new == 8'd0) begin
                                            n_rising = 1'b1;
                                            n_pch    = (r_pch == PCH_GREEN) ? PCH_RED
                                                                            : r_pch + 2'd1;
                                        end
                                    end
                                end
                                PROG_FLASH: begin
                                    sc       = r_step + 8'd1;
                                    n_step   = sc;
                                    n_fcount = sc;
                                    case (r_phase)
                                        PH_WAIT: begin
                                            if (sc == r_span) begin
                                                n_phase = PH_FADE_IN;
                                                n_span  = w_s64;
                                                n_step  = 8'd0;
                                                n_tb    = i_rand1;
                                                n_tg    = i_rand2;
                                                n_tr    = i_rand3;
                                            end
                                        end
                                        PH_FADE_IN: begin
                                            if (sc == r_span) begin
                                                n_phase = PH_HOLD;
                                                n_step  = 8'd0;
                                                n_red   = r_tr;
                                                n_green = r_tg;
                                                n_blue  = r_tb;
                                            end else begin
                                                need_fade = 1'b1;
                                                n_fmode   = FM_UP;
                                            end
                                        end
                                        PH_HOLD: begin
                                            if (sc == r_span) begin
                                                n_phase = PH_FADE_OUT;
                                                n_step  = 8'd0;
                                            end
                                        end
                                        default: begin
                                            if (sc == r_span) begin
                                                n_phase = PH_WAIT;
                                                n_span  = span_from_draw(i_rand0);
                                                n_step  = 8'd0;
                                                n_red   = 8'd0;
                                                n_green = 8'd0;
                                                n_blue  = 8'd0;
                                            end else begin
                                                need_fade = 1'b1;
                                                n_fmode   = FM_DOWN;
                                            end
                                        end
                                    endcase
                                end
                                default: ;  // white holds
                            endcase
                        end
                        CMD_NEXT: begin
                            n_prog = (r_prog >= PROG_FLASH) ? PROG_BLIP : r_prog + 3'd1;
                            case (n_prog)
                                PROG_BLIP: begin
                                    n_step  = w_s127;
                                    n_phase = PH_WAIT;
                                    n_red   = 8'd255;
                                    n_green = 8'd255;
                                    n_blue  = 8'd255;
                                end
                                PROG_WHITE: begin
                                    n_red   = 8'd255;
                                    n_green = 8'd255;
                                    n_blue  = 8'd255;
                                end
                                PROG_RAINBOW: begin
                                    n_red   = 8'd255;
                                    n_green = 8'd0;
                                    n_blue  = 8'd0;
                                    n_phase = PH_WAIT;
                                end
                                PROG_PULSE: begin
                                    n_red    = 8'd0;
                                    n_green  = 8'd0;
                                    n_blue   = 8'd0;
                                    n_pch    = PCH_RED;
                                    n_rising = 1'b1;
                                end
                                default: begin
                                    n_step  = 8'd0;
                                    n_phase = PH_WAIT;
                                    n_span  = {1'b0, i_rand0[6:0]} + 8'd1;
                                    n_red   = 8'd0;
                                    n_green = 8'd0;
                                    n_blue  = 8'd0;
                                end
                            endcase
                        end
                        CMD_POWER: n_power = ~r_power;
                        default: ;  // unused command
                    endcase
                    n_chan  = CH_RED;
                    n_state = need_fade ? CS_ISSUE : CS_DONE;
                end
            end
            CS_ISSUE: n_state = CS_WAIT;
            CS_WAIT: begin
                if (i_fade_done) begin
                    case (r_chan)
                        CH_RED:   n_red   = i_fade_level;
                        CH_GREEN: n_green = i_fade_level;
                        default:  n_blue  = i_fade_level;
                    endcase
                    if (r_chan == CH_BLUE) begin
                        n_state = CS_DONE;
                    end else begin
                        n_chan  = r_chan + 2'd1;
                        n_state = CS_ISSUE;
                    end
                end
            end
            CS_DONE: begin
                if (i_res_ready) n_state = CS_IDLE;
            end
            default: n_state = CS_IDLE;
        endcase
    end

    // fade request for the current channel
    always_comb begin
        logic [7:0] tgt;
        case (r_chan)
            CH_RED:   tgt = r_tr;
            CH_GREEN: tgt = r_tg;
            default:  tgt = r_tb;
        endcase
        o_fade_req.count = r_fcount;
        o_fade_req.span  = r_span;
        case (r_fmode)
            FM_TO_WHITE: begin
                o_fade_req.from = tgt;
                o_fade_req.to   = 8'd255;
            end
            FM_FROM_WHITE: begin
                o_fade_req.from = 8'd255;
                o_fade_req.to   = tgt;
            end
            FM_UP: begin
                o_fade_req.from = 8'd0;
                o_fade_req.to   = tgt;
            end
            default: begin
                o_fade_req.from = tgt;
                o_fade_req.to   = 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= CS_IDLE;
            r_chan   <= CH_RED;
            r_prog   <= PROG_BLIP;
            r_power  <= 1'b1;
            r_red    <= 8'd255;
            r_green  <= 8'd255;
            r_blue   <= 8'd255;
            r_phase  <= PH_WAIT;
            r_step   <= 8'd127;
            r_span   <= 8'd0;
            r_tr     <= 8'd0;
            r_tg     <= 8'd0;
            r_tb     <= 8'd0;
            r_rising <= 1'b1;
            r_pch    <= PCH_RED;
        end else begin
            r_state  <= n_state;
            r_chan   <= n_chan;
            r_prog   <= n_prog;
            r_power  <= n_power;
            r_red    <= n_red;
            r_green  <= n_green;
            r_blue   <= n_blue;
            r_phase  <= n_phase;
            r_step   <= n_step;
            r_span   <= n_span;
            r_tr     <= n_tr;
            r_tg     <= n_tg;
            r_tb     <= n_tb;
            r_rising <= n_rising;
            r_pch    <= n_pch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fmode  <= n_fmode;
        r_fcount <= n_fcount;
    end

    assign o_ready      = (r_state == CS_IDLE);
    assign o_res_valid  = (r_state == CS_DONE);
    assign o_fade_start = (r_state == CS_ISSUE);

    assign o_res.red_pwm     = r_red;
    assign o_res.green_pwm   = r_green;
    assign o_res.blue_pwm    = r_blue;
    assign o_res.leds_on     = r_power;
    assign o_res.program_now = r_prog;

endmodule

// ===== src/rgb_led_effect_sequencer.sv =====
// RGB LED effect sequencer: top level with stream ports and output register.
// Depends on rles_pkg, rles_core and rles_fade_unit.
//
// Slave channel takes one word per step: tuser carries the command (tick,
// next program, power toggle), tdata four 15-bit random draws. Master
// channel returns one word per accepted input: three 8-bit levels, the
// power flag and the active program.
// Sequence: a step with no fade goes from the core's done state into the
// output register. A fading tick (blip and flash fade phases) first runs
// the shared fade unit once per color channel (issue, eight 2-bit divide
// iterations, finish, write back) before it reaches the done state.
// Flow: one step at a time; s_axis tready drops at acceptance and
// returns once the result has moved into the output register.
// Stall: a stalled master holds its word; the next step may still be
// accepted, and its result then waits in the core with tready low.
// Reset (synchronous, active low): program blip, power on, levels white,
// blip hold count 127; no output word pending.
module rgb_led_effect_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // rand_0[14:0], rand_1, rand_2, rand_3, pad[63:60]
    input  logic [1:0]  i_s_axis_tuser,   // command[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // red, green, blue, leds_on, program_now, pad
);
    import rles_pkg::*;

    logic       w_accept;
    logic       w_core_ready;
    logic       w_res_valid;
    logic       w_res_take;
    t_result    w_res;
    logic       w_fade_start;
    t_fade_req  w_fade_req;
    logic       w_fade_done;
    logic [7:0] w_fade_level;

    logic       r_m_valid, n_m_valid;
    t_result    r_m_data;

    assign w_accept   = i_s_axis_tvalid && w_core_ready;
    assign w_res_take = !r_m_valid || i_m_axis_tready;

    rles_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_accept),
        .i_cmd        (i_s_axis_tuser),
        .i_rand0      (i_s_axis_tdata[14:0]),
        .i_rand1      (i_s_axis_tdata[22:15]),
        .i_rand2      (i_s_axis_tdata[37:30]),
        .i_rand3      (i_s_axis_tdata[52:45]),
        .o_ready      (w_core_ready),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_take),
        .o_res        (w_res),
        .o_fade_start (w_fade_start),
        .o_fade_req   (w_fade_req),
        .i_fade_done  (w_fade_done),
        .i_fade_level (w_fade_level)
    );

    rles_fade_unit u_fade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_fade_start),
        .i_req   (w_fade_req),
        .o_done  (w_fade_done),
        .o_level (w_fade_level)
    );

    // output register: loads whenever empty or being drained
    always_comb begin
        n_m_valid = r_m_valid;
        if (w_res_take) n_m_valid = w_res_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take && w_res_valid) r_m_data <= w_res;
    end

    assign o_s_axis_tready = w_core_ready;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {4'b0000, r_m_data.program_now, r_m_data.leds_on,
                              r_m_data.blue_pwm, r_m_data.green_pwm,
                              r_m_data.red_pwm};

endmodule

// ===== src/rles_checker.sv =====
// Port-level checks for the LED effect sequencer, bound to the top level.
// Depends on rles_pkg and rgb_led_effect_sequencer_assert.svh.
module rles_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_vld,
    input logic        i_in_rdy,
    input logic        i_out_vld,
    input logic        i_out_rdy,
    input logic [31:0] i_out_data
);
    import rles_pkg::*;
`include "rgb_led_effect_sequencer_assert.svh"

    // a stalled output word holds
    `RLES_ASSERT_NXT(a_out_hold, i_clk, !i_rst_n, i_out_vld && !i_out_rdy, i_out_vld && $stable(i_out_data))

    // one step in flight: input closes right after a word is taken
    `RLES_ASSERT_NXT(a_busy_after_accept, i_clk, !i_rst_n, i_in_vld && i_in_rdy, !i_in_rdy)

    // reported program is always one of the five
    `RLES_ASSERT_IMP(a_prog_range, i_clk, !i_rst_n, i_out_vld, i_out_data[27:25] <= PROG_FLASH)

    // reset drops any pending output word
    `RLES_ASSERT_NXT(a_reset_flush, i_clk, 1'b0, !i_rst_n, !i_out_vld)

endmodule

bind rgb_led_effect_sequencer rles_checker u_rles_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_vld   (i_s_axis_tvalid),
    .i_in_rdy   (o_s_axis_tready),
    .i_out_vld  (o_m_axis_tvalid),
    .i_out_rdy  (i_m_axis_tready),
    .i_out_data (o_m_axis_tdata)
);

// ===== verif/rgb_led_effect_sequencer_tb.sv =====
// Self-checking testbench for rgb_led_effect_sequencer: stream stimulus, effect predictor.
// Depends on rles_pkg and the rgb_led_effect_sequencer RTL.
`timescale 1ns / 100ps

module rgb_led_effect_sequencer_tb;
    import rles_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;   // no-op command, state reported as is
    localparam int ITEMS        = 1450;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 64;           // more than a fading tick needs to reach the output
    localparam int HOLD_CYCLES  = 400;          // long master stall, fills the output stage
    localparam int HOLD_AT_WORD = 1100;

    // Effect predictor and store of due levels.
    class led_scoreboard;
        logic [2:0] prog;
        logic       power;
        logic [7:0] red, green, blue;
        logic [1:0] phase;
        logic [7:0] cnt;
        logic [7:0] span;
        logic [7:0] tgt_r, tgt_g, tgt_b;
        logic       rising;
        logic [1:0] chan;
        t_result    levels_due[$];
        int         errors;
        int         checked;
        int         prog_ticks[5];

        function new();
            prog   = PROG_BLIP;
            power  = 1'b1;
            red    = 8'd255;
            green  = 8'd255;
            blue   = 8'd255;
            phase  = PH_WAIT;
            cnt    = 8'd127;
            span   = 8'd0;
            tgt_r  = 8'd0;
            tgt_g  = 8'd0;
            tgt_b  = 8'd0;
            rising = 1'b1;
            chan   = PCH_RED;
            errors = 0;
            checked = 0;
            foreach (prog_ticks[i]) prog_ticks[i] = 0;
        endfunction

        // count*(to-from)/len + from, signed division truncating toward zero
        function logic [7:0] fade(logic [7:0] count, logic [7:0] len,
                                  logic [7:0] from, logic [7:0] to);
            int num;
            int q;
            if (len == 8'd0) return from;
            num = int'(count) * (int'(to) - int'(from));
            q = num / int'(len) + int'(from);
            return q[7:0];
        endfunction

        function void set_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            red   = r;
            green = g;
            blue  = b;
        endfunction

        function void enter(logic [14:0] r0);
            case (prog)
                PROG_BLIP: begin
                    cnt   = 8'(r0[6:0]) + 8'd127;
                    phase = PH_WAIT;
                    set_rgb(8'd255, 8'd255, 8'd255);
                end
                PROG_WHITE: set_rgb(8'd255, 8'd255, 8'd255);
                PROG_RAINBOW: begin
                    set_rgb(8'd255, 8'd0, 8'd0);
                    phase = PH_WAIT;
                end
                PROG_PULSE: begin
                    set_rgb(8'd0, 8'd0, 8'd0);
                    chan   = PCH_RED;
                    rising = 1'b1;
                end
                default: begin
                    cnt   = 8'd0;
                    phase = PH_WAIT;
                    span  = 8'(r0[6:0]) + 8'd1;
                    set_rgb(8'd0, 8'd0, 8'd0);
                end
            endcase
        endfunction

        // blip counts down: white hold, fade in, hold, fade back out
        function void blip_tick(logic [14:0] r0, logic [14:0] r1,
                                logic [14:0] r2, logic [14:0] r3);
            cnt = cnt - 8'd1;
            case (phase)
                PH_WAIT: begin
                    if (cnt == 8'd0) begin
                        phase = PH_FADE_IN;
                        cnt   = 8'(r0[5:0]) + 8'd64;
                        span  = cnt;
                        tgt_b = r1[7:0];
                        tgt_r = r2[7:0];
                        tgt_g = r3[7:0];
                    end
                end
                PH_FADE_IN: begin
                    set_rgb(fade(cnt, span, tgt_r, 8'd255),
                            fade(cnt, span, tgt_g, 8'd255),
                            fade(cnt, span, tgt_b, 8'd255));
                    if (cnt == 8'd0) begin
                        phase = PH_HOLD;
                        cnt   = 8'(r0[5:0]) + 8'd1;
                    end
                end
                PH_HOLD: begin
                    if (cnt == 8'd0) begin
                        phase = PH_FADE_OUT;
                        cnt   = 8'(r0[5:0]) + 8'd64;
                        span  = cnt;
                    end
                end
                default: begin
                    set_rgb(fade(cnt, span, 8'd255, tgt_r),
                            fade(cnt, span, 8'd255, tgt_g),
                            fade(cnt, span, 8'd255, tgt_b));
                    if (cnt == 8'd0) begin
                        phase = PH_WAIT;
                        cnt   = 8'(r0[6:0]) + 8'd127;
                    end
                end
            endcase
        endfunction

        // flash counts up to span in every phase
        function void flash_tick(logic [14:0] r0, logic [14:0] r1,
                                 logic [14:0] r2, logic [14:0] r3);
            int wait_len;
            cnt = cnt + 8'd1;
            case (phase)
                PH_WAIT: begin
                    if (cnt == span) begin
                        phase = PH_FADE_IN;
                        span  = 8'(r0[5:0]) + 8'd64;
                        cnt   = 8'd0;
                        tgt_b = r1[7:0];
                        tgt_g = r2[7:0];
                        tgt_r = r3[7:0];
                    end
                end
                PH_FADE_IN: begin
                    if (cnt == span) begin
                        phase = PH_HOLD;
                        cnt   = 8'd0;
                        set_rgb(tgt_r, tgt_g, tgt_b);
                    end else begin
                        set_rgb(fade(cnt, span, 8'd0, tgt_r),
                                fade(cnt, span, 8'd0, tgt_g),
                                fade(cnt, span, 8'd0, tgt_b));
                    end
                end
                PH_HOLD: begin
                    if (cnt == span) begin
                        phase = PH_FADE_OUT;
                        cnt   = 8'd0;
                    end
                end
                default: begin
                    if (cnt == span) begin
                        wait_len = int'(r0) % 254 + 1;
                        phase = PH_WAIT;
                        span  = wait_len[7:0];
                        cnt   = 8'd0;
                        set_rgb(8'd0, 8'd0, 8'd0);
                    end else begin
                        set_rgb(fade(cnt, span, tgt_r, 8'd0),
                                fade(cnt, span, tgt_g, 8'd0),
                                fade(cnt, span, tgt_b, 8'd0));
                    end
                end
            endcase
        endfunction

        function void rainbow_tick();
            case (phase)
                PH_WAIT: begin
                    red  = red - 8'd1;
                    blue = blue + 8'd1;
                    if (red == 8'd0) phase = PH_FADE_IN;
                end
                PH_FADE_IN: begin
                    blue  = blue - 8'd1;
                    green = green + 8'd1;
                    if (blue == 8'd0) phase = PH_HOLD;
                end
                PH_HOLD: begin
                    green = green - 8'd1;
                    red   = red + 8'd1;
                    if (green == 8'd0) phase = PH_WAIT;
                end
                default: phase = PH_WAIT;
            endcase
        endfunction

        // one channel ramps up then down, order red, blue, green
        function void pulse_tick();
            logic [7:0] lvl;
            logic [1:0] stepped;
            stepped = chan;
            case (chan)
                PCH_RED:   lvl = red;
                PCH_BLUE:  lvl = blue;
                PCH_GREEN: lvl = green;
                default:   return;
            endcase
            if (rising) begin
                lvl = lvl + 8'd1;
                if (lvl == 8'd255) rising = 1'b0;
            end else begin
                lvl = lvl - 8'd1;
                if (lvl == 8'd0) begin
                    rising = 1'b1;
                    chan   = (chan == PCH_GREEN) ? PCH_RED : chan + 2'd1;
                end
            end
            // write back to the channel that was stepped
            case (stepped)
                PCH_RED:  red   = lvl;
                PCH_BLUE: blue  = lvl;
                default:  green = lvl;
            endcase
        endfunction

        // accepted input word: advance the predictor, queue the due levels
        function void take_step(logic [1:0] cmd, logic [14:0] r0, logic [14:0] r1,
                                logic [14:0] r2, logic [14:0] r3);
            t_result due;
            case (cmd)
                CMD_TICK: begin
                    if (prog <= PROG_FLASH) prog_ticks[prog]++;
                    case (prog)
                        PROG_BLIP:    blip_tick(r0, r1, r2, r3);
                        PROG_RAINBOW: rainbow_tick();
                        PROG_PULSE:   pulse_tick();
                        PROG_FLASH:   flash_tick(r0, r1, r2, r3);
                        default: ;
                    endcase
                end
                CMD_NEXT: begin
                    prog = (prog >= PROG_FLASH) ? PROG_BLIP : prog + 3'd1;
                    enter(r0);
                end
                CMD_POWER: power = ~power;
                default: ;
            endcase
            due.red_pwm     = red;
            due.green_pwm   = green;
            due.blue_pwm    = blue;
            due.leds_on     = power;
            due.program_now = prog;
            levels_due.push_back(due);
        endfunction

        function int pending();
            return levels_due.size();
        endfunction

        task report_miss(string what);
            $display("[%0t] mismatch at word %0d: %s", $realtime, checked, what);
            errors++;
        endtask

        task check_word(logic [31:0] word);
            t_result got;
            t_result due;
            got = word[27:0];
            if (levels_due.size() == 0) begin
                report_miss($sformatf("word %h arrived with nothing due", word));
                return;
            end
            due = levels_due.pop_front();
            checked++;
            if (got.red_pwm != due.red_pwm)
                report_miss($sformatf("red %0d, expected %0d", got.red_pwm, due.red_pwm));
            if (got.green_pwm != due.green_pwm)
                report_miss($sformatf("green %0d, expected %0d",
                                      got.green_pwm, due.green_pwm));
            if (got.blue_pwm != due.blue_pwm)
                report_miss($sformatf("blue %0d, expected %0d", got.blue_pwm, due.blue_pwm));
            if (got.leds_on != due.leds_on)
                report_miss($sformatf("leds_on %0b, expected %0b", got.leds_on, due.leds_on));
            if (got.program_now != due.program_now)
                report_miss($sformatf("program %0d, expected %0d",
                                      got.program_now, due.program_now));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata;   // rand_0, rand_1, rand_2, rand_3 (15 bits each), pad
    logic [1:0]  i_s_axis_tuser;   // command
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;   // red, green, blue, leds_on, program_now, pad

    led_scoreboard sb;
    int sent;
    int tx_idle_pct;
    int rx_idle_pct;
    int cycles;
    int hold_left;
    bit hold_done;

    rgb_led_effect_sequencer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d words still due", cycles, sb.pending());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Master side: check each accepted word, then pick tready for the next edge.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
                sb.check_word(o_m_axis_tdata);
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (!hold_done && sb.checked >= HOLD_AT_WORD) begin
                // long stall while the sender keeps offering: input side must back up
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic [14:0] draw_word();
        return 15'($urandom);
    endfunction

    // rand_0 with short waits most of the time, so effects cycle within the run
    function automatic logic [14:0] draw_pace();
        logic [14:0] w;
        w = 15'($urandom);
        if ($urandom_range(0, 99) < 60) w[6:0] = 7'($urandom_range(0, 3));
        return w;
    endfunction

    task automatic push_step(input logic [1:0] cmd, input logic [14:0] r0,
                             input logic [14:0] r1, input logic [14:0] r2,
                             input logic [14:0] r3);
        if (sent < ITEMS / 3) begin
            tx_idle_pct = 32;
            rx_idle_pct = 88;
        end else if (sent < 2 * ITEMS / 3) begin
            tx_idle_pct = 88;
            rx_idle_pct = 32;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'd0, r3, r2, r1, r0};
        i_s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.take_step(cmd, r0, r1, r2, r3);
        sent++;
    endtask

    initial begin
        int pick;
        int seg;
        int roll;
        logic [2:0] want;
        logic [1:0] cmd;

        sb = new();
        sent = 0;
        cycles = 0;
        hold_left = 0;
        hold_done = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = CMD_TICK;
        i_m_axis_tready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, every command and program, power off ticking.
        push_step(CMD_TICK, 15'h0000, 15'h0000, 15'h0000, 15'h0000);
        push_step(CMD_TICK, 15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff);
        push_step(CMD_UNUSED, 15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff);
        push_step(CMD_POWER, 15'h5555, 15'h2aaa, 15'h5555, 15'h2aaa);
        push_step(CMD_TICK, 15'h2aaa, 15'h5555, 15'h2aaa, 15'h5555);
        push_step(CMD_NEXT, 15'h7fff, 15'h0000, 15'h0000, 15'h0000);    // white
        push_step(CMD_TICK, 15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff);
        push_step(CMD_NEXT, 15'h0000, 15'h0000, 15'h0000, 15'h0000);    // rainbow
        push_step(CMD_TICK, 15'h0000, 15'h0000, 15'h0000, 15'h0000);
        push_step(CMD_TICK, 15'h0000, 15'h0000, 15'h0000, 15'h0000);
        push_step(CMD_NEXT, 15'h0000, 15'h0000, 15'h0000, 15'h0000);    // pulse
        push_step(CMD_TICK, 15'h0000, 15'h0000, 15'h0000, 15'h0000);
        push_step(CMD_TICK, 15'h0000, 15'h0000, 15'h0000, 15'h0000);
        push_step(CMD_POWER, 15'h0000, 15'h0000, 15'h0000, 15'h0000);
        push_step(CMD_NEXT, 15'h0000, 15'h0000, 15'h0000, 15'h0000);    // flash, span 1
        push_step(CMD_TICK, 15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff);    // starts fade up
        push_step(CMD_TICK, 15'h0000, 15'h0000, 15'h0000, 15'h0000);
        push_step(CMD_TICK, 15'h0000, 15'h0000, 15'h0000, 15'h0000);
        push_step(CMD_NEXT, 15'h0000, 15'h7fff, 15'h7fff, 15'h7fff);    // wraps to blip
        push_step(CMD_TICK, 15'h0000, 15'h0000, 15'h0000, 15'h0000);

        // Random: long runs of ticks in one program, with power, next and no-op noise.
        while (sent < ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                want = PROG_BLIP;
                seg = $urandom_range(250, 600);
            end else if (pick < 80) begin
                want = PROG_FLASH;
                seg = $urandom_range(200, 450);
            end else if (pick < 87) begin
                want = PROG_RAINBOW;
                seg = $urandom_range(30, 150);
            end else if (pick < 94) begin
                want = PROG_PULSE;
                seg = $urandom_range(30, 150);
            end else begin
                want = PROG_WHITE;
                seg = $urandom_range(5, 20);
            end
            while (sb.prog != want && sent < ITEMS)
                push_step(CMD_NEXT, draw_pace(), draw_word(), draw_word(), draw_word());
            for (int k = 0; k < seg && sent < ITEMS; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    cmd = CMD_POWER;
                else if (roll < 5)
                    cmd = CMD_UNUSED;
                else if (roll < 7)
                    cmd = CMD_NEXT;
                else
                    cmd = CMD_TICK;
                push_step(cmd, draw_pace(), draw_word(), draw_word(), draw_word());
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d steps sent, %0d words checked in %0d cycles", sent, sb.checked, cycles);
        $display("ticks per program: blip %0d white %0d rainbow %0d pulse %0d flash %0d",
                 sb.prog_ticks[0], sb.prog_ticks[1], sb.prog_ticks[2],
                 sb.prog_ticks[3], sb.prog_ticks[4]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
